### src/qafs_pkg.sv
// ----------------------------------------------------------------------------
// qafs_pkg
// Shared types and byte constants for the quote-aware field splitter.
// ----------------------------------------------------------------------------
`default_nettype none

package qafs_pkg;

    localparam logic [7:0] DELIM_RESET = 8'd44;
    localparam logic [7:0] MAXF_RESET  = 8'd0;

    localparam logic [1:0] CFG_DELIMITER  = 2'd0;
    localparam logic [1:0] CFG_MAX_FIELDS = 2'd1;

    localparam logic [1:0] MODE_TOP    = 2'd0;
    localparam logic [1:0] MODE_QUOTE  = 2'd1;
    localparam logic [1:0] MODE_BRACK  = 2'd2;
    localparam logic [1:0] MODE_BQUOTE = 2'd3;

    localparam logic [1:0] KIND_NONE = 2'd3;

    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_DQUOTE = 8'h22;
    localparam logic [7:0] CH_SQUOTE = 8'h27;
    localparam logic [7:0] CH_BQUOTE = 8'h60;
    localparam logic [7:0] CH_BSLASH = 8'h5C;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       keep;
        logic       field_end;
        logic [7:0] field_index;
        logic       last;
        logic       final_field_present;
    } t_result;

    function automatic logic is_space(input logic [7:0] b);
        return (b == CH_SPACE) || (b == CH_TAB) || (b == CH_LF) || (b == CH_CR);
    endfunction

    function automatic logic [1:0] quote_code(input logic [7:0] b);
        case (b)
            CH_DQUOTE: quote_code = 2'd0;
            CH_SQUOTE: quote_code = 2'd1;
            CH_BQUOTE: quote_code = 2'd2;
            default:   quote_code = KIND_NONE;
        endcase
    endfunction

    function automatic logic [1:0] open_code(input logic [7:0] b);
        case (b)
            8'h28:   open_code = 2'd0;
            8'h5B:   open_code = 2'd1;
            8'h7B:   open_code = 2'd2;
            default: open_code = KIND_NONE;
        endcase
    endfunction

    function automatic logic [7:0] quote_byte(input logic [1:0] k);
        case (k)
            2'd0:    quote_byte = CH_DQUOTE;
            2'd1:    quote_byte = CH_SQUOTE;
            2'd2:    quote_byte = CH_BQUOTE;
            default: quote_byte = 8'h00;
        endcase
    endfunction

    function automatic logic [7:0] open_byte(input logic [1:0] k);
        case (k)
            2'd0:    open_byte = 8'h28;
            2'd1:    open_byte = 8'h5B;
            2'd2:    open_byte = 8'h7B;
            default: open_byte = 8'h00;
        endcase
    endfunction

    function automatic logic [7:0] close_byte(input logic [1:0] k);
        case (k)
            2'd0:    close_byte = 8'h29;
            2'd1:    close_byte = 8'h5D;
            2'd2:    close_byte = 8'h7D;
            default: close_byte = 8'h00;
        endcase
    endfunction

endpackage

`default_nettype wire

### src/qafs_scan.sv
// ----------------------------------------------------------------------------
// qafs_scan
// Scanner state, config registers and per-byte classification.
// ----------------------------------------------------------------------------
`default_nettype none

module qafs_scan #(
    parameter int NEST_BITS = 8
) (
    input  wire                   i_clk,
    input  wire                   i_rst_n,
    input  wire                   i_cfg_we,
    input  wire  [1:0]            i_cfg_index,
    input  wire  [7:0]            i_cfg_data,
    input  wire                   i_accept,
    input  wire  [7:0]            i_text_byte,
    input  wire                   i_is_last,
    output qafs_pkg::t_result     o_result
);

    localparam logic [NEST_BITS-1:0] NEST_MAX = {NEST_BITS{1'b1}};
    localparam logic [NEST_BITS-1:0] NEST_ONE = {{(NEST_BITS-1){1'b0}}, 1'b1};

    logic [7:0]           r_delim,  r_maxf;
    logic [1:0]           r_mode,   n_mode;
    logic [1:0]           r_qkind,  n_qkind;
    logic [1:0]           r_bkind,  n_bkind;
    logic [NEST_BITS-1:0] r_nest,   n_nest;
    logic                 r_esc,    n_esc;
    logic                 r_skip,   n_skip;
    logic [7:0]           r_fdone,  n_fdone;
    logic                 r_htext,  n_htext;

    logic       keep, fend, limited;
    logic [1:0] qc, oc;

    always_comb begin
        qc      = qafs_pkg::quote_code(i_text_byte);
        oc      = qafs_pkg::open_code(i_text_byte);
        limited = (r_maxf != 8'd0) && (({1'b0, r_fdone} + 9'd1) >= {1'b0, r_maxf});
        keep    = 1'b1;
        fend    = 1'b0;
        n_mode  = r_mode;
        n_qkind = r_qkind;
        n_bkind = r_bkind;
        n_nest  = r_nest;
        n_esc   = r_esc;
        n_skip  = r_skip;
        n_fdone = r_fdone;
        n_htext = r_htext;
        case (r_mode)
            qafs_pkg::MODE_TOP: begin
                if (r_skip && !qafs_pkg::is_space(r_delim)
                        && qafs_pkg::is_space(i_text_byte)) begin
                    keep = 1'b0;
                end else begin
                    n_skip = 1'b0;
                    if (limited) begin
                        keep = 1'b1;
                    end else if (qc != qafs_pkg::KIND_NONE) begin
                        n_mode  = qafs_pkg::MODE_QUOTE;
                        n_qkind = qc;
                        n_esc   = 1'b0;
                    end else if (oc != qafs_pkg::KIND_NONE) begin
                        n_mode  = qafs_pkg::MODE_BRACK;
                        n_bkind = oc;
                        n_nest  = NEST_ONE;
                        n_esc   = 1'b0;
                    end else if (i_text_byte == r_delim) begin
                        keep    = 1'b0;
                        fend    = 1'b1;
                        if (r_fdone != 8'hFF) n_fdone = r_fdone + 8'd1;
                        n_htext = 1'b0;
                        n_skip  = 1'b1;
                    end
                end
            end
            qafs_pkg::MODE_QUOTE, qafs_pkg::MODE_BQUOTE: begin
                if (r_esc) begin
                    n_esc = 1'b0;
                end else if (i_text_byte == qafs_pkg::quote_byte(r_qkind)) begin
                    n_mode = (r_mode == qafs_pkg::MODE_BQUOTE) ?
                             qafs_pkg::MODE_BRACK : qafs_pkg::MODE_TOP;
                end else if (i_text_byte == qafs_pkg::CH_BSLASH) begin
                    n_esc = 1'b1;
                end
            end
            default: begin
                if (r_esc) begin
                    n_esc = 1'b0;
                end else if (qc != qafs_pkg::KIND_NONE) begin
                    n_mode  = qafs_pkg::MODE_BQUOTE;
                    n_qkind = qc;
                end else if (i_text_byte == qafs_pkg::open_byte(r_bkind)) begin
                    if (r_nest != NEST_MAX) n_nest = r_nest + NEST_ONE;
                end else if (i_text_byte == qafs_pkg::close_byte(r_bkind)) begin
                    if (r_nest != '0) n_nest = r_nest - NEST_ONE;
                    if (n_nest == '0) n_mode = qafs_pkg::MODE_TOP;
                end else if (i_text_byte == qafs_pkg::CH_BSLASH) begin
                    n_esc = 1'b1;
                end
            end
        endcase
        if (keep) n_htext = 1'b1;

        o_result.out_byte            = i_text_byte;
        o_result.keep                = keep;
        o_result.field_end           = fend;
        o_result.field_index         = r_fdone;
        o_result.last                = i_is_last;
        o_result.final_field_present = i_is_last & n_htext;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_delim <= qafs_pkg::DELIM_RESET;
            r_maxf  <= qafs_pkg::MAXF_RESET;
        end else if (i_cfg_we) begin
            if (i_cfg_index == qafs_pkg::CFG_DELIMITER)  r_delim <= i_cfg_data;
            if (i_cfg_index == qafs_pkg::CFG_MAX_FIELDS) r_maxf  <= i_cfg_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (i_accept && i_is_last)) begin
            r_mode  <= qafs_pkg::MODE_TOP;
            r_qkind <= 2'd0;
            r_bkind <= 2'd0;
            r_nest  <= '0;
            r_esc   <= 1'b0;
            r_skip  <= 1'b1;
            r_fdone <= 8'd0;
            r_htext <= 1'b0;
        end else if (i_accept) begin
            r_mode  <= n_mode;
            r_qkind <= n_qkind;
            r_bkind <= n_bkind;
            r_nest  <= n_nest;
            r_esc   <= n_esc;
            r_skip  <= n_skip;
            r_fdone <= n_fdone;
            r_htext <= n_htext;
        end
    end

endmodule

`default_nettype wire

### src/qafs_skid.sv
// ----------------------------------------------------------------------------
// qafs_skid
// Result register with one skid entry; stall to the source is registered.
// ----------------------------------------------------------------------------
`default_nettype none

module qafs_skid (
    input  wire                     i_clk,
    input  wire                     i_rst_n,
    input  wire                     i_valid,
    output logic                    o_stall,
    input  wire  qafs_pkg::t_result i_data,
    output logic                    o_valid,
    input  wire                     i_stall,
    output qafs_pkg::t_result       o_data
);

    logic              r_main_v, r_skid_v;
    qafs_pkg::t_result r_main,   r_skid;
    logic              accept, take;

    assign o_stall = r_skid_v;
    assign accept  = i_valid && !r_skid_v;
    assign take    = r_main_v && !i_stall;
    assign o_valid = r_main_v;
    assign o_data  = r_main;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_main_v <= 1'b0;
            r_skid_v <= 1'b0;
        end else if (take) begin
            if (r_skid_v) begin
                r_main   <= r_skid;
                r_skid_v <= 1'b0;
            end else begin
                r_main_v <= accept;
                r_main   <= i_data;
            end
        end else if (!r_main_v) begin
            r_main_v <= accept;
            r_main   <= i_data;
        end else if (accept) begin
            r_skid   <= i_data;
            r_skid_v <= 1'b1;
        end
    end

endmodule

`default_nettype wire

### src/quote_aware_field_splitter.sv
// ----------------------------------------------------------------------------
// quote_aware_field_splitter
// An accepted byte's result is registered in a two-entry buffer: the main
// result register, plus a skid entry that takes one more byte while a result
// is stalled, then raises o_stall. One byte per cycle while o_stall is low.
// Reset (synchronous, active low) restores delimiter 44, no field limit,
// and top-level scan state; results in flight are dropped.
// ----------------------------------------------------------------------------
`default_nettype none

module quote_aware_field_splitter #(
    parameter int NEST_BITS = 8
) (
    input  wire        i_clk,
    input  wire        i_rst_n,
    input  wire        i_cfg_we,
    input  wire  [1:0] i_cfg_index,
    input  wire  [7:0] i_cfg_data,
    input  wire        i_valid,
    output logic       o_stall,
    input  wire  [7:0] i_text_byte,
    input  wire        i_is_last,
    output logic       o_valid,
    input  wire        i_stall,
    output logic [7:0] o_out_byte,
    output logic       o_keep,
    output logic       o_field_end,
    output logic [7:0] o_field_index,
    output logic       o_last,
    output logic       o_final_field_present
);

    qafs_pkg::t_result scan_res, out_res;
    logic              accept;

    assign accept = i_valid && !o_stall;

    qafs_scan #(
        .NEST_BITS (NEST_BITS)
    ) u_scan (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_accept    (accept),
        .i_text_byte (i_text_byte),
        .i_is_last   (i_is_last),
        .o_result    (scan_res)
    );

    qafs_skid u_skid (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .i_data  (scan_res),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .o_data  (out_res)
    );

    assign o_out_byte            = out_res.out_byte;
    assign o_keep                = out_res.keep;
    assign o_field_end           = out_res.field_end;
    assign o_field_index         = out_res.field_index;
    assign o_last                = out_res.last;
    assign o_final_field_present = out_res.final_field_present;

endmodule

`default_nettype wire
